@@ hw/rtl/ofdm_subcarrier_symbol_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// OFDM subcarrier symbol mapper - assertion macros
// Shared concurrent assertion forms used by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef OFDM_SUBCARRIER_SYMBOL_MAPPER_DEFINES_SVH
`define OFDM_SUBCARRIER_SYMBOL_MAPPER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define OSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define OSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/osm_pkg.sv @@
// ----------------------------------------------------------------------------
// osm_pkg
// Types, codes and constellation tables of the OFDM subcarrier symbol mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package osm_pkg;

    localparam int CARRIER_W = 6;
    localparam int REF_DEPTH = 64;
    localparam int PHASE_W   = 4;
    localparam int SAMPLE_W  = 16;
    localparam int MOD_W     = 4;
    localparam int MODE_W    = 2;
    localparam int BITS_W    = 8;

    // Modulation register codes
    localparam logic [MOD_W-1:0] MOD_BPSK   = 4'd0;
    localparam logic [MOD_W-1:0] MOD_QPSK   = 4'd1;
    localparam logic [MOD_W-1:0] MOD_8PSK   = 4'd2;
    localparam logic [MOD_W-1:0] MOD_16QAM  = 4'd3;
    localparam logic [MOD_W-1:0] MOD_32QAM  = 4'd4;
    localparam logic [MOD_W-1:0] MOD_64QAM  = 4'd5;
    localparam logic [MOD_W-1:0] MOD_256QAM = 4'd6;
    localparam logic [MOD_W-1:0] MOD_DBPSK  = 4'd7;
    localparam logic [MOD_W-1:0] MOD_DQPSK  = 4'd8;
    localparam logic [MOD_W-1:0] MOD_D8PSK  = 4'd9;

    // Item mode codes
    localparam logic [MODE_W-1:0] MODE_MAP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Offset that turns a cosine step into the matching sine step
    localparam logic [PHASE_W-1:0] SIN_OFFSET = 4'd12;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Reference phase write-back request
    typedef struct packed {
        logic                 en;
        logic [CARRIER_W-1:0] addr;
        logic [PHASE_W-1:0]   phase;
    } ref_wr_t;

    // Cosine of step * 22.5 degrees in Q2.14
    function automatic sample_t unit_cos(input logic [PHASE_W-1:0] step);
        sample_t v;
        case (step)
            4'd0:    v = 16'sd16384;
            4'd1:    v = 16'sd15137;
            4'd2:    v = 16'sd11585;
            4'd3:    v = 16'sd6270;
            4'd4:    v = 16'sd0;
            4'd5:    v = -16'sd6270;
            4'd6:    v = -16'sd11585;
            4'd7:    v = -16'sd15137;
            4'd8:    v = -16'sd16384;
            4'd9:    v = -16'sd15137;
            4'd10:   v = -16'sd11585;
            4'd11:   v = -16'sd6270;
            4'd12:   v = 16'sd0;
            4'd13:   v = 16'sd6270;
            4'd14:   v = 16'sd11585;
            default: v = 16'sd15137;
        endcase
        return v;
    endfunction

    // Gray index of the 8PSK phase
    function automatic logic [2:0] psk8_index(input logic [2:0] b);
        logic [2:0] v;
        case (b)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd1;
            3'd2:    v = 3'd3;
            3'd3:    v = 3'd2;
            3'd4:    v = 3'd7;
            3'd5:    v = 3'd6;
            3'd6:    v = 3'd4;
            default: v = 3'd5;
        endcase
        return v;
    endfunction

    function automatic sample_t lev16(input logic [1:0] b);
        sample_t v;
        case (b)
            2'd0:    v = -16'sd15543;
            2'd1:    v = -16'sd5181;
            2'd2:    v = 16'sd15543;
            default: v = 16'sd5181;
        endcase
        return v;
    endfunction

    function automatic sample_t lev32_i(input logic [1:0] b);
        sample_t v;
        case (b)
            2'd0:    v = -16'sd9640;
            2'd1:    v = -16'sd3213;
            2'd2:    v = 16'sd9640;
            default: v = 16'sd3213;
        endcase
        return v;
    endfunction

    function automatic sample_t lev32_q(input logic [2:0] b);
        sample_t v;
        case (b)
            3'd0:    v = -16'sd22492;
            3'd1:    v = -16'sd16066;
            3'd2:    v = -16'sd3213;
            3'd3:    v = -16'sd9640;
            3'd4:    v = 16'sd22492;
            3'd5:    v = 16'sd16066;
            3'd6:    v = 16'sd3213;
            default: v = 16'sd9640;
        endcase
        return v;
    endfunction

    function automatic sample_t lev64(input logic [2:0] b);
        sample_t v;
        case (b)
            3'd0:    v = -16'sd17697;
            3'd1:    v = -16'sd12641;
            3'd2:    v = -16'sd2528;
            3'd3:    v = -16'sd7584;
            3'd4:    v = 16'sd17697;
            3'd5:    v = 16'sd12641;
            3'd6:    v = 16'sd2528;
            default: v = 16'sd7584;
        endcase
        return v;
    endfunction

    function automatic sample_t lev256(input logic [3:0] b);
        sample_t v;
        case (b)
            4'd0:    v = -16'sd15864;
            4'd1:    v = -16'sd13749;
            4'd2:    v = -16'sd9518;
            4'd3:    v = -16'sd11633;
            4'd4:    v = -16'sd1058;
            4'd5:    v = -16'sd3173;
            4'd6:    v = -16'sd7403;
            4'd7:    v = -16'sd5288;
            4'd8:    v = 16'sd15864;
            4'd9:    v = 16'sd13749;
            4'd10:   v = 16'sd9518;
            4'd11:   v = 16'sd11633;
            4'd12:   v = 16'sd1058;
            4'd13:   v = 16'sd3173;
            4'd14:   v = 16'sd7403;
            default: v = 16'sd5288;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/osm_ref_store.sv @@
// ----------------------------------------------------------------------------
// osm_ref_store
// Per-carrier reference phase memory with valid bits and write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ofdm_subcarrier_symbol_mapper_defines.svh"

module osm_ref_store
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [osm_pkg::CARRIER_W-1:0]    rd_addr,
    input  logic [osm_pkg::CARRIER_W-1:0]    cur_addr,
    input  osm_pkg::ref_wr_t                 wr,
    input  logic                             clear,
    output logic [osm_pkg::PHASE_W-1:0]      ref_phase
);

    logic [osm_pkg::PHASE_W-1:0]   mem [osm_pkg::REF_DEPTH];
    logic [osm_pkg::PHASE_W-1:0]   rd_data_reg;
    logic [osm_pkg::REF_DEPTH-1:0] valid_reg;
    logic [osm_pkg::REF_DEPTH-1:0] valid_next;
    logic                          fwd_valid_reg;
    logic [osm_pkg::CARRIER_W-1:0] fwd_addr_reg;
    logic [osm_pkg::PHASE_W-1:0]   fwd_phase_reg;
    logic                          fwd_hit;

    // Write back the updated phase, read the next carrier's phase
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.phase;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Mark written entries, drop all marks on restart
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    // Capture the write that lands on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                fwd_valid_reg <= wr.en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_addr_reg  <= wr.addr;
            fwd_phase_reg <= wr.phase;
        end
    end

    // Select forwarded, stored or zero phase
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == cur_addr);

    always_comb
    begin
        if (fwd_hit)
        begin
            ref_phase = fwd_phase_reg;
        end
        else if (valid_reg[cur_addr])
        begin
            ref_phase = rd_data_reg;
        end
        else
        begin
            ref_phase = '0;
        end
    end

    `OSM_ASSERT(a_clear_empties, clk, rst_n, clear |=> (valid_reg == '0),
        "restart left a reference marked valid")
    `OSM_ASSERT(a_write_marks, clk, rst_n, wr.en |=> valid_reg[$past(wr.addr)],
        "written reference not marked valid")
    `OSM_ASSERT_NEVER(a_clear_and_write, clk, rst_n, clear && wr.en,
        "restart and phase write in the same cycle")

endmodule

@@ hw/rtl/osm_point_map.sv @@
// ----------------------------------------------------------------------------
// osm_point_map
// Turns one bit group into an I/Q point, coherent or differential.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module osm_point_map
(
    input  logic [osm_pkg::MOD_W-1:0]    modulation,
    input  logic                         do_map,
    input  logic [osm_pkg::BITS_W-1:0]   bits,
    input  logic [osm_pkg::PHASE_W-1:0]  ref_phase,
    output osm_pkg::sample_t             point_i,
    output osm_pkg::sample_t             point_q,
    output logic                         phase_wr,
    output logic [osm_pkg::PHASE_W-1:0]  new_phase
);

    logic                        diff_mod;
    logic [osm_pkg::PHASE_W-1:0] rot;
    logic [osm_pkg::PHASE_W-1:0] psk_step;
    osm_pkg::sample_t            coh_i;
    osm_pkg::sample_t            coh_q;

    assign diff_mod = (modulation == osm_pkg::MOD_DBPSK) ||
                      (modulation == osm_pkg::MOD_DQPSK) ||
                      (modulation == osm_pkg::MOD_D8PSK);

    assign psk_step = {osm_pkg::psk8_index(bits[2:0]), 1'b1};

    // Pick the differential rotation
    always_comb
    begin
        case (modulation)
            osm_pkg::MOD_DBPSK: rot = bits[0] ? 4'd8 : 4'd0;
            osm_pkg::MOD_DQPSK: rot = {bits[1:0], 2'b00};
            default:            rot = psk_step;
        endcase
    end

    assign new_phase = ref_phase + rot;
    assign phase_wr  = do_map && diff_mod;

    // Coherent constellations
    always_comb
    begin
        case (modulation)
            osm_pkg::MOD_BPSK:
            begin
                coh_i = bits[0] ? 16'sd16384 : -16'sd16384;
                coh_q = 16'sd0;
            end
            osm_pkg::MOD_8PSK:
            begin
                coh_i = osm_pkg::unit_cos(psk_step);
                coh_q = osm_pkg::unit_cos(psk_step + osm_pkg::SIN_OFFSET);
            end
            osm_pkg::MOD_16QAM:
            begin
                coh_i = osm_pkg::lev16(bits[3:2]);
                coh_q = osm_pkg::lev16(bits[1:0]);
            end
            osm_pkg::MOD_32QAM:
            begin
                coh_i = osm_pkg::lev32_i(bits[1:0]);
                coh_q = osm_pkg::lev32_q(bits[4:2]);
            end
            osm_pkg::MOD_64QAM:
            begin
                coh_i = osm_pkg::lev64(bits[5:3]);
                coh_q = osm_pkg::lev64(bits[2:0]);
            end
            osm_pkg::MOD_256QAM:
            begin
                coh_i = osm_pkg::lev256(bits[7:4]);
                coh_q = osm_pkg::lev256(bits[3:0]);
            end
            default:
            begin
                coh_i = bits[1] ? 16'sd11585 : -16'sd11585;
                coh_q = bits[0] ? 16'sd11585 : -16'sd11585;
            end
        endcase
    end

    // Choose differential, coherent or zero point
    always_comb
    begin
        if (!do_map)
        begin
            point_i = '0;
            point_q = '0;
        end
        else if (diff_mod)
        begin
            point_i = osm_pkg::unit_cos(new_phase);
            point_q = osm_pkg::unit_cos(new_phase + osm_pkg::SIN_OFFSET);
        end
        else
        begin
            point_i = coh_i;
            point_q = coh_q;
        end
    end

endmodule

@@ hw/rtl/ofdm_subcarrier_symbol_mapper.sv @@
// ----------------------------------------------------------------------------
// ofdm_subcarrier_symbol_mapper
// Maps subcarrier bit groups to Q2.14 I/Q points, with per-carrier
// differential PSK references held in a synchronous memory.
//
//   channel  | direction | handshake           | beat
//   item     | in        | item_valid/stall    | mode, carrier, group_bits, last
//   point    | out       | point_valid/stall   | in_phase, quadrature, carrier, end
//   cfg      | in        | cfg_valid/ready     | cfg_data -> modulation
//
// One beat per clock sustained while point_stall is low. The accept edge reads
// the carrier's reference and loads the stage; the output register then loads
// from the stage once it is not held by point_stall, and drives point_valid.
// The stage takes its reference from the memory read plus a one-entry forward.
// Reset clears all references at once through per-carrier valid bits; the
// block takes items in the first cycle after reset.
// point_stall holds the output register and, with a full stage, the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ofdm_subcarrier_symbol_mapper_defines.svh"

module ofdm_subcarrier_symbol_mapper
#(
    parameter int ACTIVE_CARRIERS = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [osm_pkg::MOD_W-1:0]        cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [osm_pkg::MODE_W-1:0]       mode,
    input  logic [osm_pkg::CARRIER_W-1:0]    carrier,
    input  logic [osm_pkg::BITS_W-1:0]       group_bits,
    input  logic                             last_in_symbol,
    output logic                             point_valid,
    input  logic                             point_stall,
    output logic signed [osm_pkg::SAMPLE_W-1:0] in_phase,
    output logic signed [osm_pkg::SAMPLE_W-1:0] quadrature,
    output logic [osm_pkg::CARRIER_W-1:0]    out_carrier,
    output logic                             symbol_end
);

    logic [osm_pkg::MOD_W-1:0]     modulation_reg;
    logic                          s1_valid_reg;
    logic [osm_pkg::MODE_W-1:0]    s1_mode_reg;
    logic [osm_pkg::CARRIER_W-1:0] s1_carrier_reg;
    logic [osm_pkg::BITS_W-1:0]    s1_bits_reg;
    logic                          s1_last_reg;
    logic                          point_valid_reg;
    logic                          point_valid_next;
    osm_pkg::sample_t              in_phase_reg;
    osm_pkg::sample_t              quadrature_reg;
    logic [osm_pkg::CARRIER_W-1:0] out_carrier_reg;
    logic                          symbol_end_reg;

    logic                          item_load;
    logic                          s1_has_res;
    logic                          s1_adv;
    logic                          point_load;
    logic                          in_range;
    logic                          do_map;
    logic [osm_pkg::PHASE_W-1:0]   ref_phase;
    logic [osm_pkg::PHASE_W-1:0]   new_phase;
    logic                          phase_wr;
    osm_pkg::sample_t              map_i;
    osm_pkg::sample_t              map_q;
    osm_pkg::ref_wr_t              ref_wr;
    logic                          ref_clear;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg <= osm_pkg::MOD_QPSK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            modulation_reg <= cfg_data;
        end
    end

    // Stage and output handshake
    assign s1_has_res = (s1_mode_reg == osm_pkg::MODE_MAP) ||
                        (s1_mode_reg == osm_pkg::MODE_PAD);
    assign s1_adv     = s1_valid_reg &&
                        (!s1_has_res || !point_valid_reg || !point_stall);
    assign point_load = s1_adv && s1_has_res;
    assign item_stall = s1_valid_reg && !s1_adv;
    assign item_load  = item_valid && !item_stall;

    assign point_valid_next = point_load || (point_valid_reg && point_stall);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            point_valid_reg <= point_valid_next;
        end
    end

    // Advance payload through the stage and the output register
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            s1_mode_reg    <= mode;
            s1_carrier_reg <= carrier;
            s1_bits_reg    <= group_bits;
            s1_last_reg    <= last_in_symbol;
        end
        if (point_load)
        begin
            in_phase_reg    <= map_i;
            quadrature_reg  <= map_q;
            out_carrier_reg <= s1_carrier_reg;
            symbol_end_reg  <= s1_last_reg;
        end
    end

    // Carriers past the configured count act as pads
    assign in_range = int'(s1_carrier_reg) < ACTIVE_CARRIERS;
    assign do_map   = (s1_mode_reg == osm_pkg::MODE_MAP) && in_range;

    assign ref_wr.en    = s1_adv && phase_wr;
    assign ref_wr.addr  = s1_carrier_reg;
    assign ref_wr.phase = new_phase;
    assign ref_clear    = s1_adv && (s1_mode_reg == osm_pkg::MODE_RESTART);

    osm_ref_store u_ref_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (item_load),
        .rd_addr   (carrier),
        .cur_addr  (s1_carrier_reg),
        .wr        (ref_wr),
        .clear     (ref_clear),
        .ref_phase (ref_phase)
    );

    osm_point_map u_point_map
    (
        .modulation (modulation_reg),
        .do_map     (do_map),
        .bits       (s1_bits_reg),
        .ref_phase  (ref_phase),
        .point_i    (map_i),
        .point_q    (map_q),
        .phase_wr   (phase_wr),
        .new_phase  (new_phase)
    );

    assign point_valid = point_valid_reg;
    assign in_phase    = in_phase_reg;
    assign quadrature  = quadrature_reg;
    assign out_carrier = out_carrier_reg;
    assign symbol_end  = symbol_end_reg;

    `OSM_ASSERT(a_result_loads, clk, rst_n, point_load |=> point_valid,
        "mapped beat did not reach the output register")
    `OSM_ASSERT(a_stall_cause, clk, rst_n,
        item_stall |-> (s1_valid_reg && point_valid_reg && point_stall),
        "input stalled without a blocked output")
    `OSM_ASSERT_NEVER(a_write_needs_map, clk, rst_n, ref_wr.en && !do_map,
        "reference written by a beat that is not mapped")

endmodule
